// File: rtl/irrigation_run_timer_top_defines.svh
// ----------------------------------------------------------------------------
// irrigation_run_timer_top_defines
// assertion macros for the pump run timer, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef IRRIGATION_RUN_TIMER_TOP_DEFINES_SVH
`define IRRIGATION_RUN_TIMER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every clock edge outside reset
`define IRT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("irrigation_run_timer: assertion failed");
// checked on every clock edge, reset included
`define IRT_ASSERT_NR(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("irrigation_run_timer: assertion failed");
`else
`define IRT_ASSERT(lbl, prop)
`define IRT_ASSERT_NR(lbl, prop)
`endif

`endif

// File: rtl/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// types, codes and constants shared by the pump run timer modules
// ----------------------------------------------------------------------------
`default_nettype none

package irt_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_HALT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_ON   = 2'd1,
		CMD_HALT = 2'd2,
		CMD_STOP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CHANGED       = 3'd0,
		ST_NOT_ADDRESSED = 3'd1,
		ST_TOO_SHORT     = 3'd2,
		ST_TOO_LONG      = 3'd3,
		ST_NO_RULE       = 3'd4,
		ST_TICK_SAME     = 3'd5
	} status_t;

	// configuration register indexes
	localparam logic [1:0] CFG_DEVICE_ID   = 2'd0;
	localparam logic [1:0] CFG_MIN_MINUTES = 2'd1;
	localparam logic [1:0] CFG_MAX_MINUTES = 2'd2;

	localparam logic [10:0] MAX_MINUTES_RESET = 11'd60;

	// watering windows, lower bound inclusive, upper bound exclusive
	localparam logic [4:0] WIN_AM_LO = 5'd7;
	localparam logic [4:0] WIN_AM_HI = 5'd9;
	localparam logic [4:0] WIN_PM_LO = 5'd16;
	localparam logic [4:0] WIN_PM_HI = 5'd19;

	// seconds to minutes: floor(x * 139811 / 2^23) equals floor(x / 60) for x < 2^17
	localparam logic [17:0] MIN_RECIP = 18'd139811;
	localparam int          MIN_SHIFT = 23;

	typedef struct packed {
		logic [15:0] device_id;
		logic [10:0] min_minutes;
		logic [10:0] max_minutes;
	} cfg_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] target_id;
		logic [16:0] duration_seconds;
		logic [4:0]  hour;
		logic        time_valid;
	} item_t;

	typedef struct packed {
		mode_t       mode;
		logic [16:0] rem;
		status_t     status;
		logic        win;
	} step_res_t;

	// minutes * 60 as (m << 6) - (m << 2), fits 17 bits for any 11-bit m
	function automatic logic [16:0] mins_to_secs(input logic [10:0] m);
		logic [16:0] w;
		w = {6'b0, m};
		return (w << 6) - (w << 2);
	endfunction

endpackage

`default_nettype wire

// File: rtl/irrigation_run_timer_top.sv
// ----------------------------------------------------------------------------
// irrigation_run_timer_top
// pump run timer: idle / running / halted, driven by second ticks and
// addressed on, halt and stop commands, with hour-window gating
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   ------------------------------------------
//   input     in_valid / in_stall     cmd, target_id, duration_seconds, hour,
//                                     time_valid
//   output    out_valid / out_stall   run_state, pump_on, remaining_minutes,
//                                     window_open, status, publish
//   config    cfg_we                  cfg_index, cfg_wdata
//
// one beat in, one beat out; a beat can be taken on every cycle that in_stall is low
// a beat passes the input register, then the result register
// the path between them is the state update plus one 17x18 multiply for minutes
// in_stall rises only when both registers hold a beat and out_stall is high
// reset clears both valid flags, the mode to idle, the remaining time to zero
// and the config registers to device id 0, min 0 and max 60 minutes
// ----------------------------------------------------------------------------
`default_nettype none
`include "irrigation_run_timer_top_defines.svh"

module irrigation_run_timer_top import irt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// config write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,

	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] target_id,
	input  wire logic [16:0] duration_seconds,
	input  wire logic [4:0]  hour,
	input  wire logic        time_valid,

	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       run_state,
	output logic             pump_on,
	output logic [10:0]      remaining_minutes,
	output logic             window_open,
	output logic [2:0]       status,
	output logic             publish
);

	cfg_t        cfg;

	// input register
	logic        vld_s1;
	item_t       item_s1;

	// timer state
	mode_t       mode_q;
	logic [16:0] rem_q;

	// result register
	logic        vld_s2;
	mode_t       mode_s2;
	logic [10:0] minutes_s2;
	logic        win_s2;
	status_t     status_s2;

	step_res_t   res;
	logic [10:0] minutes;
	logic        adv_s1;
	logic        acc_in;

	irt_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// the held beat moves on when the result register is empty or being drained
	assign adv_s1   = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv_s1;
	assign acc_in   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc_in) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			item_s1.cmd              <= cmd_t'(cmd);
			item_s1.target_id        <= target_id;
			item_s1.duration_seconds <= duration_seconds;
			item_s1.hour             <= hour;
			item_s1.time_valid       <= time_valid;
		end
	end

	irt_step u_step (
		.item (item_s1),
		.cfg  (cfg),
		.mode (mode_q),
		.rem  (rem_q),
		.res  (res)
	);

	irt_min_conv u_min_conv (
		.secs    (res.rem),
		.minutes (minutes)
	);

	// timer state commits together with the beat leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			rem_q  <= '0;
		end else if (adv_s1) begin
			mode_q <= res.mode;
			rem_q  <= res.rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mode_s2    <= res.mode;
			minutes_s2 <= minutes;
			win_s2     <= res.win;
			status_s2  <= res.status;
		end
	end

	assign out_valid         = vld_s2;
	assign run_state         = mode_s2;
	assign pump_on           = (mode_s2 == MODE_RUN);
	assign remaining_minutes = minutes_s2;
	assign window_open       = win_s2;
	assign status            = status_s2;
	// a report goes out whenever the status says changed, also for a stop while idle
	assign publish           = (status_s2 == ST_CHANGED);

	// idle never keeps any remaining time
	`IRT_ASSERT(a_idle_no_time, (mode_q == MODE_IDLE) |-> (rem_q == 17'd0))
	// the timer state moves only with a beat passing through
	`IRT_ASSERT(a_state_held, !adv_s1 |=> ($stable(mode_q) && $stable(rem_q)))
	// back-pressure on the input only while a beat is held there
	`IRT_ASSERT_NR(a_stall_full, in_stall |-> vld_s1)

endmodule

`default_nettype wire

// File: rtl/irt_cfg_regs.sv
// ----------------------------------------------------------------------------
// irt_cfg_regs
// configuration register file: device id and the duration limits
// ----------------------------------------------------------------------------
`default_nettype none

module irt_cfg_regs import irt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        we,
	input  wire logic [1:0]  index,
	input  wire logic [15:0] wdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id   <= '0;
			cfg_q.min_minutes <= '0;
			cfg_q.max_minutes <= MAX_MINUTES_RESET;
		end else if (we) begin
			unique case (index)
				CFG_DEVICE_ID:   cfg_q.device_id   <= wdata;
				CFG_MIN_MINUTES: cfg_q.min_minutes <= wdata[10:0];
				CFG_MAX_MINUTES: cfg_q.max_minutes <= wdata[10:0];
				default:         ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/irt_step.sv
// ----------------------------------------------------------------------------
// irt_step
// next mode, remaining seconds and status for one tick or command
// ----------------------------------------------------------------------------
`default_nettype none

module irt_step import irt_pkg::*; (
	input  wire item_t       item,
	input  wire cfg_t        cfg,
	input  wire mode_t       mode,
	input  wire logic [16:0] rem,
	output step_res_t        res
);

	logic        win;
	logic [16:0] min_secs;
	logic [16:0] max_secs;

	assign win = item.time_valid &&
		((item.hour >= WIN_AM_LO && item.hour < WIN_AM_HI) ||
		 (item.hour >= WIN_PM_LO && item.hour < WIN_PM_HI));

	assign min_secs = mins_to_secs(cfg.min_minutes);
	assign max_secs = mins_to_secs(cfg.max_minutes);

	always_comb begin
		res.mode   = mode;
		res.rem    = rem;
		res.status = ST_NO_RULE;
		res.win    = win;
		if (item.cmd == CMD_TICK) begin
			res.status = ST_TICK_SAME;
			if (mode == MODE_RUN) begin
				if (!win) begin
					// run left the window
					res.mode   = MODE_HALT;
					res.status = ST_CHANGED;
				end else if (rem <= 17'd1) begin
					res.mode   = MODE_IDLE;
					res.rem    = '0;
					res.status = ST_CHANGED;
				end else begin
					res.rem = rem - 17'd1;
				end
			end
		end else if (item.target_id != cfg.device_id) begin
			res.status = ST_NOT_ADDRESSED;
		end else if (item.cmd == CMD_ON && item.duration_seconds <= min_secs) begin
			res.status = ST_TOO_SHORT;
		end else if (item.cmd == CMD_ON && item.duration_seconds > max_secs) begin
			res.status = ST_TOO_LONG;
		end else if (item.cmd == CMD_ON && mode == MODE_IDLE && win) begin
			res.mode   = MODE_RUN;
			res.rem    = item.duration_seconds;
			res.status = ST_CHANGED;
		end else if (item.cmd == CMD_ON && mode == MODE_HALT && win) begin
			// resume with the kept time
			res.mode   = MODE_RUN;
			res.status = ST_CHANGED;
		end else if (item.cmd == CMD_HALT && mode == MODE_RUN) begin
			res.mode   = MODE_HALT;
			res.status = ST_CHANGED;
		end else if (item.cmd == CMD_STOP) begin
			res.mode   = MODE_IDLE;
			res.rem    = '0;
			res.status = ST_CHANGED;
		end
	end

endmodule

`default_nettype wire

// File: rtl/irt_min_conv.sv
// ----------------------------------------------------------------------------
// irt_min_conv
// whole minutes from seconds by reciprocal multiplication
// ----------------------------------------------------------------------------
`default_nettype none

module irt_min_conv import irt_pkg::*; (
	input  wire logic [16:0] secs,
	output logic [10:0]      minutes
);

	logic [34:0] prod;

	assign prod    = {18'b0, secs} * {17'b0, MIN_RECIP};
	// quotient is 12 bits wide, upper bit dropped as the field is 11 bits
	assign minutes = prod[MIN_SHIFT +: 11];

endmodule

`default_nettype wire

// File: test/irrigation_run_timer_top_tb.sv
// ----------------------------------------------------------------------------
// irrigation_run_timer_top_tb
// self-checking bench for the pump run timer: a queue-fed driver pushes tick
// and command beats, a scoreboard model predicts every result beat, and a
// clocked monitor compares each field; register settings change between
// phases once no beat is in flight; most phases put random gaps on both channels
// ----------------------------------------------------------------------------
module irrigation_run_timer_top_tb import irt_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// one expected result beat, field for field as on the output ports
	typedef struct packed {
		logic [1:0]  run_state;
		logic        pump_on;
		logic [10:0] remaining_minutes;
		logic        window_open;
		logic [2:0]  status;
		logic        publish;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_DEVICE_ID;
	logic [15:0] cfg_wdata = '0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_TICK;
	logic [15:0] target_id = '0;
	logic [16:0] duration_seconds = '0;
	logic [4:0]  hour = '0;
	logic        time_valid = 1'b0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  run_state;
	logic        pump_on;
	logic [10:0] remaining_minutes;
	logic        window_open;
	logic [2:0]  status;
	logic        publish;

	// beats waiting to be driven, and results waiting to come out
	item_t   cmd_backlog[$];
	report_t pending_reports[$];
	item_t   fed_beat;

	// scoreboard copy of the registers and of the timer state
	logic [15:0] cfg_device = '0;
	logic [10:0] cfg_min = '0;
	logic [10:0] cfg_max = MAX_MINUTES_RESET;
	mode_t       pump_mode = MODE_IDLE;
	logic [16:0] secs_left = '0;

	// gap rates in percent, changed between phases
	int unsigned send_idle_pct = 12;
	int unsigned recv_stall_pct = 67;

	int unsigned mismatches = 0;
	int unsigned queued = 0;
	int unsigned beats_sent = 0;
	int unsigned beats_checked = 0;
	int unsigned settings_seen = 1;
	int unsigned runs_started = 0;
	int unsigned runs_resumed = 0;
	int unsigned runs_completed = 0;
	int unsigned window_halts = 0;

	irrigation_run_timer_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.cmd               (cmd),
		.target_id         (target_id),
		.duration_seconds  (duration_seconds),
		.hour              (hour),
		.time_valid        (time_valid),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.run_state         (run_state),
		.pump_on           (pump_on),
		.remaining_minutes (remaining_minutes),
		.window_open       (window_open),
		.status            (status),
		.publish           (publish)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// watering windows: morning 7-8 and late afternoon 16-18, bounds from the package
	function automatic logic hour_open(input logic [4:0] h);
		return (h >= WIN_AM_LO && h < WIN_AM_HI) || (h >= WIN_PM_LO && h < WIN_PM_HI);
	endfunction

	// advance the timer by one beat and return the result it should report
	function automatic report_t step_timer(input logic [1:0] op, input logic [15:0] tgt,
			input logic [16:0] dur, input logic [4:0] hr, input logic tv);
		report_t     r;
		logic        win;
		status_t     st;
		int unsigned floor_secs;
		int unsigned ceil_secs;
		win = tv && hour_open(hr);
		floor_secs = cfg_min * 60;
		ceil_secs = cfg_max * 60;
		if (op == CMD_TICK) begin
			// target and duration mean nothing on a tick
			st = ST_TICK_SAME;
			if (pump_mode == MODE_RUN) begin
				if (!win) begin
					pump_mode = MODE_HALT;
					st = ST_CHANGED;
					window_halts++;
				end else if (secs_left <= 1) begin
					// last second used up, count saturates at zero
					pump_mode = MODE_IDLE;
					secs_left = '0;
					st = ST_CHANGED;
					runs_completed++;
				end else begin
					secs_left = secs_left - 1'b1;
				end
			end
		end else if (tgt != cfg_device) begin
			st = ST_NOT_ADDRESSED;
		end else if (op == CMD_ON && dur <= floor_secs) begin
			st = ST_TOO_SHORT;
		end else if (op == CMD_ON && dur > ceil_secs) begin
			st = ST_TOO_LONG;
		end else if (op == CMD_ON && pump_mode == MODE_IDLE && win) begin
			secs_left = dur;
			pump_mode = MODE_RUN;
			st = ST_CHANGED;
			runs_started++;
		end else if (op == CMD_ON && pump_mode == MODE_HALT && win) begin
			// resume keeps the frozen count, the new duration is dropped
			pump_mode = MODE_RUN;
			st = ST_CHANGED;
			runs_resumed++;
		end else if (op == CMD_HALT && pump_mode == MODE_RUN) begin
			pump_mode = MODE_HALT;
			st = ST_CHANGED;
		end else if (op == CMD_STOP) begin
			// an addressed stop always reports a change, even from idle
			pump_mode = MODE_IDLE;
			secs_left = '0;
			st = ST_CHANGED;
		end else begin
			st = ST_NO_RULE;
		end
		r.run_state = pump_mode;
		r.pump_on = (pump_mode == MODE_RUN);
		r.remaining_minutes = 11'(secs_left / 60);
		r.window_open = win;
		r.status = st;
		r.publish = (st == ST_CHANGED);
		return r;
	endfunction

	// driver: take the beat on the handshake, then load the next one or go idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_reports.push_back(
					step_timer(cmd, target_id, duration_seconds, hour, time_valid));
				beats_sent++;
			end
			// a stalled beat holds its payload and its valid
			if (!in_valid || !in_stall) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					fed_beat = cmd_backlog.pop_front();
					in_valid <= 1'b1;
					cmd <= fed_beat.cmd;
					target_id <= fed_beat.target_id;
					duration_seconds <= fed_beat.duration_seconds;
					hour <= fed_beat.hour;
					time_valid <= fed_beat.time_valid;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// monitor: random back-pressure, compare every accepted result beat
	always @(posedge clk) begin
		report_t want;
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: result beat with nothing expected, status %0d",
						$time, status);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					check_field("run_state", want.run_state, run_state);
					check_field("pump_on", want.pump_on, pump_on);
					check_field("remaining_minutes", want.remaining_minutes,
						remaining_minutes);
					check_field("window_open", want.window_open, window_open);
					check_field("status", want.status, status);
					check_field("publish", want.publish, publish);
					beats_checked++;
				end
			end
		end
	end

	// register write, mirrored into the scoreboard copy with the register widths
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_DEVICE_ID:   cfg_device = val;
			CFG_MIN_MINUTES: cfg_min = val[10:0];
			CFG_MAX_MINUTES: cfg_max = val[10:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [15:0] dev, input logic [15:0] lo_raw,
			input logic [15:0] hi_raw);
		write_reg(CFG_DEVICE_ID, dev);
		write_reg(CFG_MIN_MINUTES, lo_raw);
		write_reg(CFG_MAX_MINUTES, hi_raw);
		settings_seen++;
	endtask

	// wait until every beat is in and every result has come back
	task automatic drain();
		do @(posedge clk);
		while (cmd_backlog.size() != 0 || in_valid || pending_reports.size() != 0);
	endtask

	task automatic push_beat(input cmd_t op, input logic [15:0] tgt, input logic [16:0] dur,
			input logic [4:0] hr, input logic tv);
		item_t b;
		b.cmd = op;
		b.target_id = tgt;
		b.duration_seconds = dur;
		b.hour = hr;
		b.time_valid = tv;
		cmd_backlog.push_back(b);
		queued++;
	endtask

	function automatic logic [4:0] open_hour();
		if ($urandom_range(1))
			return WIN_AM_LO + 5'($urandom_range(WIN_AM_HI - WIN_AM_LO - 1));
		return WIN_PM_LO + 5'($urandom_range(WIN_PM_HI - WIN_PM_LO - 1));
	endfunction

	// any hour outside the windows, 19-31 and the out-of-range ones included
	function automatic logic [4:0] shut_hour();
		logic [4:0] h;
		do h = 5'($urandom);
		while (hour_open(h));
		return h;
	endfunction

	// fully random beat, mostly addressed to us so the command paths get exercised
	task automatic push_noise();
		logic [15:0] tgt;
		tgt = ($urandom_range(3) == 0) ? 16'($urandom) : cfg_device;
		push_beat(cmd_t'($urandom_range(3)), tgt, 17'($urandom), 5'($urandom),
			1'($urandom));
	endtask

	// an addressed on inside the window, then a train of ticks with the odd
	// halt, window exit, resume and stray beat, sometimes closed by a stop
	task automatic queue_watering_run();
		int unsigned lo_secs;
		int unsigned hi_secs;
		int unsigned span;
		int unsigned dur;
		int unsigned ticks;
		lo_secs = cfg_min * 60;
		hi_secs = cfg_max * 60;
		if (hi_secs > lo_secs) begin
			// mostly short runs, which can finish when there is no minimum, now and then a long one
			span = hi_secs - lo_secs - 1;
			if ($urandom_range(9) != 0 && span > 40)
				span = 40;
			dur = lo_secs + 1 + $urandom_range(span);
		end else begin
			dur = $urandom_range(17'h1FFFF);
		end
		push_beat(CMD_ON, cfg_device, 17'(dur), open_hour(), 1'b1);
		ticks = $urandom_range((dur + 2 > 60) ? 60 : dur + 2);
		repeat (ticks) begin
			case ($urandom_range(29))
				0: begin
					push_beat(CMD_TICK, 16'($urandom), 17'($urandom), shut_hour(),
						1'($urandom));
					if ($urandom_range(1))
						push_beat(CMD_ON, cfg_device, 17'(dur), open_hour(), 1'b1);
				end
				1: begin
					push_beat(CMD_HALT, cfg_device, 17'($urandom), open_hour(), 1'b1);
					if ($urandom_range(1))
						push_beat(CMD_ON, cfg_device, 17'(dur), open_hour(), 1'b1);
				end
				2: push_beat(CMD_ON, cfg_device, 17'(dur), open_hour(), 1'b1);
				3: push_noise();
				default: push_beat(CMD_TICK, 16'($urandom), 17'($urandom), open_hour(),
					1'b1);
			endcase
		end
		if ($urandom_range(3) == 0)
			push_beat(CMD_STOP, cfg_device, 17'($urandom), 5'($urandom), 1'($urandom));
	endtask

	task automatic queue_random(input int unsigned count);
		int unsigned goal;
		goal = queued + count;
		while (queued < goal) begin
			if ($urandom_range(3) != 0)
				queue_watering_run();
			else
				repeat ($urandom_range(1, 4)) push_noise();
		end
	endtask

	// hand-picked beats; expects device 16'hFFFF, min 0 and max 3 minutes
	task automatic queue_directed();
		logic [15:0] me;
		me = cfg_device;
		push_beat(CMD_TICK, 16'h0000, 17'd0, 5'd0, 1'b0);          // tick while idle
		push_beat(CMD_ON, 16'h0000, 17'd61, 5'd8, 1'b1);           // someone else's
		push_beat(CMD_ON, me, 17'd0, 5'd8, 1'b1);                  // too short
		push_beat(CMD_ON, me, 17'h1FFFF, 5'd8, 1'b1);              // too long, widest
		push_beat(CMD_ON, me, 17'd181, 5'd8, 1'b1);                // one over max
		push_beat(CMD_ON, me, 17'd2, 5'd6, 1'b1);                  // before the window
		push_beat(CMD_ON, me, 17'd2, 5'd31, 1'b1);                 // hour past 23
		push_beat(CMD_ON, me, 17'd2, 5'd8, 1'b0);                  // clock not known
		push_beat(CMD_HALT, me, 17'd0, 5'd8, 1'b1);                // halt while idle
		push_beat(CMD_ON, me, 17'd180, 5'd9, 1'b1);                // window just shut
		push_beat(CMD_ON, me, 17'd180, 5'd7, 1'b1);                // start at max
		push_beat(CMD_ON, me, 17'd60, 5'd8, 1'b1);                 // on while running
		push_beat(CMD_TICK, 16'h0000, 17'd0, 5'd18, 1'b1);         // count down
		push_beat(CMD_TICK, me, 17'd0, 5'd15, 1'b1);               // leaves window
		push_beat(CMD_TICK, me, 17'd0, 5'd16, 1'b1);               // tick while halted
		push_beat(CMD_HALT, me, 17'd0, 5'd16, 1'b1);               // halt while halted
		push_beat(CMD_ON, me, 17'd1, 5'd16, 1'b1);                 // resume
		push_beat(CMD_HALT, me, 17'd0, 5'd17, 1'b1);               // emergency halt
		push_beat(CMD_ON, me, 17'd100, 5'd17, 1'b1);               // resume again
		push_beat(CMD_STOP, 16'h7FFF, 17'd0, 5'd17, 1'b1);         // stop, wrong id
		push_beat(CMD_STOP, me, 17'h1FFFF, 5'd3, 1'b0);            // stop a run
		push_beat(CMD_STOP, me, 17'd0, 5'd0, 1'b0);                // stop while idle
		push_beat(CMD_ON, me, 17'd2, 5'd18, 1'b1);                 // two-second run
		push_beat(CMD_TICK, me, 17'd0, 5'd18, 1'b1);
		push_beat(CMD_TICK, me, 17'd0, 5'd18, 1'b1);               // runs out
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings first: device 0, no minimum, 60 minutes maximum
		queue_random(100);
		drain();

		configure(16'hFFFF, 16'd0, 16'd3);
		queue_directed();
		drain();

		configure(16'($urandom), 16'd1, 16'd10);
		queue_random(350);
		drain();

		// sender now the slow side
		send_idle_pct = 67;
		recv_stall_pct = 12;
		// upper bits set on purpose: min lands on 0 and max on 2047
		configure(16'h0000, 16'hF800, 16'hFFFF);
		queue_random(300);
		drain();

		// minimum at its top, nearly everything too short
		configure(16'($urandom), 16'd2047, 16'd2047);
		queue_random(60);
		drain();

		// back to back on both channels
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// max of zero turns every positive duration away
		configure(16'h5A5A, 16'd0, 16'd0);
		queue_random(60);
		drain();

		configure(16'($urandom), 16'd2, 16'd1440);
		queue_random(400);
		drain();

		// let the pipeline settle in case anything stray is still coming
		repeat (8) @(posedge clk);

		$display("%0d beats driven, %0d results checked, %0d register settings",
			beats_sent, beats_checked, settings_seen);
		$display("runs: %0d started, %0d resumed, %0d ran out, %0d halted by the window",
			runs_started, runs_resumed, runs_completed, window_halts);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("irrigation_run_timer_top_tb: clean");
		end else begin
			$display("irrigation_run_timer_top_tb: errors");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", pending_reports.size());
		$display("irrigation_run_timer_top_tb: errors");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/irt_pkg.sv
rtl/irt_cfg_regs.sv
rtl/irt_step.sv
rtl/irt_min_conv.sv
rtl/irrigation_run_timer_top.sv
test/irrigation_run_timer_top_tb.sv
